/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
// ASSERT_CLK_RST: checked only while reset is low.
// ASSERT_CLK: checked at every edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/pcm_mix_pkg.sv */
// ----------------------------------------------------------------------------
// pcm_mix_pkg
// Shared constants and types of the two-channel nonlinear PCM mixer.
// ----------------------------------------------------------------------------
package pcm_mix_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PIPE_DEPTH = 5;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B = 2'd1;

  localparam logic signed [17:0] MIX_MAX = 18'sd32767;
  localparam logic signed [17:0] MIX_MIN = -18'sd32768;

  // Which correction term the mix applies
  typedef enum logic [1:0] {
    MODE_SUM,
    MODE_NEG,
    MODE_POS
  } mix_mode_t;

endpackage

/* hw/rtl/pcm_mix_gain.sv */
// ----------------------------------------------------------------------------
// pcm_mix_gain
// Scales one sample by a clamped unsigned Q1.15 gain, truncating toward zero.
// Two register stages: product, then rounded-toward-zero shift.
// ----------------------------------------------------------------------------
module pcm_mix_gain import pcm_mix_pkg::*; (
  input  logic                       clk,
  input  logic                       advance,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [GAIN_W-1:0]   gain,
  output logic signed [SAMPLE_W-1:0] scaled
);

  logic        [GAIN_W-1:0] gain_eff;
  logic signed [31:0]       prod;
  logic signed [31:0]       biased;

  // Clamp the gain to unity
  assign gain_eff = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;

  // Bias negative products so the shift truncates toward zero
  assign biased = prod + (prod[31] ? 32'sd32767 : 32'sd0);

  // Stage one: multiply; stage two: shift down by 15
  always_ff @(posedge clk) begin
    if (advance) begin
      prod   <= 32'(sample) * 32'($signed({1'b0, gain_eff}));
      scaled <= biased[30:15];
    end
  end

endmodule

/* hw/rtl/pcm_mix_core.sv */
// ----------------------------------------------------------------------------
// pcm_mix_core
// Combines the two scaled samples: a + b with a product correction term,
// then saturates. Three register stages: product and sum, quotient
// estimate, correction and saturation.
// ----------------------------------------------------------------------------
module pcm_mix_core import pcm_mix_pkg::*; (
  input  logic                       clk,
  input  logic                       advance,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  output logic signed [SAMPLE_W-1:0] mixed
);

  // Stage three registers
  logic signed [31:0] ab;
  logic signed [16:0] sum;
  mix_mode_t          mode;
  mix_mode_t          mode_next;

  // Stage four registers
  logic        [30:0] ab_d;
  logic        [15:0] quot;
  logic signed [16:0] sum_d;
  mix_mode_t          mode_d;

  logic        [30:0] ab_mag;
  logic        [30:0] ab_est;
  logic        [15:0] quot_next;

  logic        [31:0] quot_times_m;
  logic        [31:0] rem;
  logic        [16:0] quot_fix;
  logic signed [17:0] mix_full;
  logic signed [SAMPLE_W-1:0] mixed_next;

  // Pick the correction from the operand signs
  always_comb begin
    if (a[SAMPLE_W-1] && b[SAMPLE_W-1]) begin
      mode_next = MODE_NEG;
    end else if (!a[SAMPLE_W-1] && (a != '0) && !b[SAMPLE_W-1] && (b != '0)) begin
      mode_next = MODE_POS;
    end else begin
      mode_next = MODE_SUM;
    end
  end

  // Estimate the quotient: by 32768 is a shift, by 32767 uses x + x/2^15
  assign ab_mag = ab[30:0];
  assign ab_est = ab_mag + {15'b0, ab_mag[30:15]};

  always_comb begin
    case (mode)
      MODE_NEG: quot_next = ab_mag[30:15];
      MODE_POS: quot_next = ab_est[30:15];
      default:  quot_next = '0;
    endcase
  end

  // Fix the estimate by one where the remainder reaches 32767
  assign quot_times_m = ({16'b0, quot} << 15) - {16'b0, quot};
  assign rem          = {1'b0, ab_d} - quot_times_m;
  assign quot_fix     = {1'b0, quot} +
                        {16'b0, (mode_d == MODE_POS) && (rem >= 32'd32767)};

  always_comb begin
    case (mode_d)
      MODE_NEG: mix_full = {sum_d[16], sum_d} + $signed({1'b0, quot_fix});
      MODE_POS: mix_full = {sum_d[16], sum_d} - $signed({1'b0, quot_fix});
      default:  mix_full = {sum_d[16], sum_d};
    endcase
  end

  // Saturate to 16 bits
  always_comb begin
    if (mix_full > MIX_MAX) begin
      mixed_next = MIX_MAX[SAMPLE_W-1:0];
    end else if (mix_full < MIX_MIN) begin
      mixed_next = MIX_MIN[SAMPLE_W-1:0];
    end else begin
      mixed_next = mix_full[SAMPLE_W-1:0];
    end
  end

  // Advance the three stages together
  always_ff @(posedge clk) begin
    if (advance) begin
      ab     <= 32'(a) * 32'(b);
      sum    <= {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      mode   <= mode_next;
      ab_d   <= ab_mag;
      quot   <= quot_next;
      sum_d  <= sum;
      mode_d <= mode;
      mixed  <= mixed_next;
    end
  end

endmodule

/* hw/rtl/pcm_two_channel_nonlinear_mixer_unit.sv */
// ----------------------------------------------------------------------------
// pcm_two_channel_nonlinear_mixer_unit
// Mixes gain-scaled channels: a+b-ab (both >0), a+b+ab (both <0), else a+b.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one sample pair (sample_a,
//   sample_b) per request. Output channel: out_valid / out_stall carry
//   mixed_sample. A request is taken when valid is high and stall is low.
//   Gains are written through cfg_write / cfg_index / cfg_data, which the
//   user must do only while the unit is idle; the unit does not enforce
//   this. Index 0 is gain_a, 1 is gain_b, others are ignored. An accepted
//   request passes through gain multiply, gain shift, cross product, quotient
//   estimate and correction/saturation stages to out_valid. Throughput: one
//   request per cycle unless stalled; every stage holds one pipeline slot.
//   Reset clears all slots and sets both gains to unity.
//   When the receiver stalls a waiting result, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pcm_two_channel_nonlinear_mixer_unit import pcm_mix_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [GAIN_W-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  sample_a,
  input  logic signed [SAMPLE_W-1:0]  sample_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  mixed_sample
);

  logic [GAIN_W-1:0]     gain_a;
  logic [GAIN_W-1:0]     gain_b;
  logic [PIPE_DEPTH-1:0] valid;
  logic                  advance;
  logic signed [SAMPLE_W-1:0] scaled_a;
  logic signed [SAMPLE_W-1:0] scaled_b;

  // Hold every stage while a finished result is stalled
  assign advance   = !valid[PIPE_DEPTH-1] || !out_stall;
  assign in_stall  = !advance;
  assign out_valid = valid[PIPE_DEPTH-1];

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_a <= GAIN_UNITY;
      gain_b <= GAIN_UNITY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN_A: gain_a <= cfg_data;
        CFG_GAIN_B: gain_b <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Shift valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[PIPE_DEPTH-2:0], in_valid};
    end
  end

  pcm_mix_gain u_gain_a (
    .clk     (clk),
    .advance (advance),
    .sample  (sample_a),
    .gain    (gain_a),
    .scaled  (scaled_a)
  );

  pcm_mix_gain u_gain_b (
    .clk     (clk),
    .advance (advance),
    .sample  (sample_b),
    .gain    (gain_b),
    .scaled  (scaled_b)
  );

  pcm_mix_core u_core (
    .clk     (clk),
    .advance (advance),
    .a       (scaled_a),
    .b       (scaled_b),
    .mixed   (mixed_sample)
  );

endmodule

/* hw/rtl/pcm_mix_checker.sv */
// ----------------------------------------------------------------------------
// pcm_mix_checker
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_mix_checker import pcm_mix_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] mixed_sample
);

  // A stalled result stays put
  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(mixed_sample), "stalled result changed")

  // Input backs up only behind a stalled result
  `ASSERT_CLK_RST(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")

  // Reset empties the pipeline
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !out_valid, "result present right after reset")

  // A free-running idle input drains to an empty output
  `ASSERT_CLK_RST(a_drain, clk, rst, !in_valid && !out_stall ##1 !in_valid && !out_stall ##1 !in_valid && !out_stall ##1 !in_valid && !out_stall ##1 !in_valid && !out_stall |=> !out_valid, "result appeared with no request in flight")

endmodule

bind pcm_two_channel_nonlinear_mixer_unit pcm_mix_checker u_pcm_mix_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .mixed_sample (mixed_sample)
);

/* verif/tb_pcm_two_channel_nonlinear_mixer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pcm_two_channel_nonlinear_mixer_unit
// Self-checking bench for the gain-scaled nonlinear PCM mixer. A local
// predictor computes every mix from the gains in force. A checker compares
// each output request in order against the pending predictions. The run
// has a directed pass over sample and gain extremes, then randomized
// phases under sender gaps and receiver stalls, and one long receiver
// hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_pcm_two_channel_nonlinear_mixer_unit;
  import pcm_mix_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_PAIRS = 130;
  localparam int MAX_REPORTS = 10;

  // Indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic       [CFG_IDX_W-1:0] cfg_index = CFG_GAIN_A;
  logic       [GAIN_W-1:0]    cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_a  = '0;
  logic signed [SAMPLE_W-1:0] sample_b  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] mixed_sample;

  // Gain registers as the unit should hold them
  logic [GAIN_W-1:0] gain_a_reg = GAIN_UNITY;
  logic [GAIN_W-1:0] gain_b_reg = GAIN_UNITY;

  logic signed [SAMPLE_W-1:0] pending_mix_q[$];
  logic signed [SAMPLE_W-1:0] want_mix;
  idle_mode_t idle_mode = IDLE_NONE;

  int holds_requested = 0;
  int holds_done      = 0;
  int mismatches      = 0;
  int mixes_checked   = 0;
  int pairs_sent      = 0;
  int gain_writes     = 0;
  int neg_terms       = 0;
  int pos_terms       = 0;

  pcm_two_channel_nonlinear_mixer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample)
  );

  always #CLK_HALF clk = ~clk;

  // Scale one sample by its gain, clamping the gain at unity, truncate toward zero
  function automatic longint scale_sample(input logic signed [SAMPLE_W-1:0] s,
                                          input logic [GAIN_W-1:0] g);
    longint gl;
    gl = longint'((g > GAIN_UNITY) ? GAIN_UNITY : g);
    return (longint'(s) * gl) / 32768;
  endfunction

  // Expected mix of one sample pair under the given gains
  function automatic logic signed [SAMPLE_W-1:0] predict_mix(
      input logic signed [SAMPLE_W-1:0] sa,
      input logic signed [SAMPLE_W-1:0] sb,
      input logic [GAIN_W-1:0] ga,
      input logic [GAIN_W-1:0] gb,
      output mix_mode_t mode);
    longint a;
    longint b;
    longint m;
    a = scale_sample(sa, ga);
    b = scale_sample(sb, gb);
    if (a < 0 && b < 0) begin
      mode = MODE_NEG;
      m = a + b + (a * b) / 32768;
    end else if (a > 0 && b > 0) begin
      mode = MODE_POS;
      m = a + b - (a * b) / 32767;
    end else begin
      mode = MODE_SUM;
      m = a + b;
    end
    if (m > MIX_MAX) m = longint'(MIX_MAX);
    if (m < MIX_MIN) m = longint'(MIX_MIN);
    return m[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return SAMPLE_W'($urandom_range(8));
      4: return SAMPLE_W'(-int'($urandom_range(8)));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(4))
      0: return GAIN_UNITY;
      1: return '0;
      2: return GAIN_W'($urandom_range(16'hFFFF, 16'h8001));
      3: return GAIN_W'($urandom_range(32768));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Offer one sample pair, hold it until taken, then idle per the current mode
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] sa,
                           input logic signed [SAMPLE_W-1:0] sb);
    mix_mode_t mode;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    sample_a <= sa;
    sample_b <= sb;
    do @(posedge clk); while (in_stall);
    pending_mix_q.push_back(predict_mix(sa, sb, gain_a_reg, gain_b_reg, mode));
    pairs_sent++;
    if (mode == MODE_NEG) neg_terms++;
    else if (mode == MODE_POS) pos_terms++;
    gap = 0;
    if (idle_mode == IDLE_SENDER) begin
      while ($urandom_range(99) < 87) gap++;
    end else if (idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < 37) gap++;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random pair, with same-sign pairs favored so both correction terms show up
  task automatic send_random_pair();
    logic signed [SAMPLE_W-1:0] sa;
    logic signed [SAMPLE_W-1:0] sb;
    sa = rand_sample();
    sb = rand_sample();
    if ($urandom_range(1)) sb[SAMPLE_W-1] = sa[SAMPLE_W-1];
    send_pair(sa, sb);
  endtask

  // Drop valid and wait for every pending mix to come out
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_mix_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                            input logic [GAIN_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_GAIN_A: gain_a_reg = value;
      CFG_GAIN_B: gain_b_reg = value;
      default: ;
    endcase
    gain_writes++;
  endtask

  // Sample extremes, zero operands, mixed signs and bit patterns at unity gain
  task automatic test_unity_extremes();
    idle_mode = IDLE_NONE;
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh0000, 16'sh8000);
    send_pair(16'sh7FFF, 16'sh0000);
    send_pair(16'sh0001, 16'sh0001);
    send_pair(16'shFFFF, 16'shFFFF);
    send_pair(16'sh5555, 16'sh5555);
    send_pair(16'shAAAA, 16'shAAAA);
    send_pair(16'sh5555, 16'shAAAA);
    drain_pipeline();
  endtask

  // Gains above unity clamp, zero and tiny gains, writes to unused indexes
  task automatic test_gain_edges();
    write_gain(CFG_GAIN_A, 16'hFFFF);
    write_gain(CFG_GAIN_B, 16'h8001);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh8000, 16'shFFFF);
    drain_pipeline();
    write_gain(CFG_GAIN_A, 16'h0000);
    write_gain(CFG_GAIN_B, 16'h0001);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    drain_pipeline();
    write_gain(CFG_SPARE_2, 16'h0000);
    write_gain(CFG_SPARE_3, 16'hFFFF);
    send_pair(16'sh4000, 16'sh8000);
    send_pair(16'shC000, 16'sh7FFF);
    drain_pipeline();
  endtask

  // Random pairs in phases, each with its own gains and idle pattern
  task automatic test_random_phases();
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      idle_mode = idle_mode_t'(phase % 4);
      case (phase)
        0: begin
          write_gain(CFG_GAIN_A, GAIN_UNITY);
          write_gain(CFG_GAIN_B, GAIN_UNITY);
        end
        1: begin
          write_gain(CFG_GAIN_A, GAIN_UNITY);
          write_gain(CFG_GAIN_B, 16'hFFFF);
        end
        default: begin
          write_gain(CFG_GAIN_A, rand_gain());
          write_gain(CFG_GAIN_B, rand_gain());
        end
      endcase
      if (phase % 2 == 1) write_gain(CFG_SPARE_3, GAIN_W'($urandom));
      repeat (PHASE_PAIRS) send_random_pair();
      drain_pipeline();
    end
  endtask

  // Hold the receiver off while the sender streams, so the input backs up
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    write_gain(CFG_GAIN_A, rand_gain());
    write_gain(CFG_GAIN_B, rand_gain());
    @(posedge clk);
    holds_requested++;
    repeat (40) send_random_pair();
    drain_pipeline();
  endtask

  // Receiver stall: a long hold-off when requested, otherwise random per mode
  initial begin : rx_stall
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != holds_requested) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (idle_mode)
          IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 87);
          IDLE_BOTH:     out_stall <= ($urandom_range(99) < 37);
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Compare each output request with the oldest pending mix
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_mix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: mix %0d arrived with nothing pending", mixed_sample);
      end else begin
        want_mix = pending_mix_q.pop_front();
        mixes_checked++;
        if (mixed_sample !== want_mix) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: mixed_sample expected %0d, got %0d (result %0d)",
                     want_mix, mixed_sample, mixes_checked);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unity_extremes();
    test_gain_edges();
    test_random_phases();
    test_backpressure();
    drain_pipeline();
    $display("Checked %0d mixes from %0d sample pairs across %0d gain writes.",
             mixes_checked, pairs_sent, gain_writes);
    $display("%0d used the both-negative term, %0d the both-positive term.",
             neg_terms, pos_terms);
    if (mismatches == 0) begin
      $display("pcm_two_channel_nonlinear_mixer_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("pcm_two_channel_nonlinear_mixer_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout with %0d mixes still pending", pending_mix_q.size());
    $display("pcm_two_channel_nonlinear_mixer_unit verification failed");
    $finish;
  end

endmodule
